@@ hdl/icymd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer package
// Result kinds, phase and matcher codes, and the title prefix table.
// ----------------------------------------------------------------------------
package icymd_pkg;

	localparam int unsigned IntervalWidth = 20;
	localparam int unsigned TotalWidth    = 48;
	localparam int unsigned RemainWidth   = 12;
	localparam int unsigned PrefixLen     = 13;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_AUDIO = 2'd0;
	localparam kind_t KIND_TITLE = 2'd1;
	localparam kind_t KIND_END   = 2'd2;

	localparam logic [1:0] PH_AUDIO  = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_META   = 2'd2;

	localparam logic [1:0] CM_PREFIX = 2'd0;
	localparam logic [1:0] CM_FIRST  = 2'd1;
	localparam logic [1:0] CM_REST   = 2'd2;
	localparam logic [1:0] CM_DONE   = 2'd3;

	localparam logic [7:0] CHAR_QUOTE = 8'h27;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_S     = 8'h53;

	function automatic logic [7:0] prefix_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h53;
			4'd1:    c = 8'h74;
			4'd2:    c = 8'h72;
			4'd3:    c = 8'h65;
			4'd4:    c = 8'h61;
			4'd5:    c = 8'h6D;
			4'd6:    c = 8'h54;
			4'd7:    c = 8'h69;
			4'd8:    c = 8'h74;
			4'd9:    c = 8'h6C;
			4'd10:   c = 8'h65;
			4'd11:   c = 8'h3D;
			4'd12:   c = 8'h27;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hdl/icy_metadata_stream_demux.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ICY metadata stream demultiplexer
// Splits a received byte stream into audio bytes and StreamTitle bytes.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on in_valid/in_ready with in_byte. Each request yields zero to
// three results on out_valid/out_ready: audio bytes, tentative title bytes
// and one block-end result per metadata block, with last marking the final
// result of a byte. meta_interval is written through meta_interval_we while
// the block is idle; zero passes every byte through as audio.
// Results of a byte pass the input register, then the result group register.
// A byte is taken in every cycle while each byte yields at most one result
// and out_ready is high; a byte that yields several results holds the single
// output register until all drain: one result per cycle while out_ready is high.
// An input register takes the next byte while a result waits on a stalled
// receiver; further bytes wait until the result group drains.
// Reset clears all state and sets meta_interval to zero, which puts the block
// in pass-through mode with audio_position counting from zero.
// ----------------------------------------------------------------------------
module icy_metadata_stream_demux (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  meta_interval_we,
	input  wire [icymd_pkg::IntervalWidth-1:0]   meta_interval,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire [7:0]                            in_byte,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output icymd_pkg::kind_t                     kind,
	output logic [7:0]                           out_byte,
	output logic                                 title_found,
	output logic [icymd_pkg::TotalWidth-1:0]     audio_position,
	output logic                                 last
);
	import icymd_pkg::*;

	logic [IntervalWidth-1:0] interval_q;
	logic [1:0]               phase_q;
	logic [IntervalWidth-1:0] count_q;
	logic [RemainWidth-1:0]   remain_q;
	logic [3:0]               match_q;
	logic [1:0]               mode_q;
	logic                     held_q;
	logic                     ended_q;
	logic                     conf_q;
	logic [TotalWidth-1:0]    total_q;

	logic                     valid_s1;
	logic [7:0]               byte_s1;

	kind_t                    grp_kind_q [3];
	logic [7:0]               grp_byte_q [3];
	logic                     grp_found_q;
	logic [TotalWidth-1:0]    grp_pos_q;
	logic [1:0]               grp_n_q;
	logic [1:0]               grp_idx_q;

	logic [1:0]               nxt_phase;
	logic [IntervalWidth-1:0] nxt_count;
	logic [IntervalWidth-1:0] count_inc;
	logic [RemainWidth-1:0]   nxt_remain;
	logic [3:0]               nxt_match;
	logic [1:0]               nxt_mode;
	logic                     nxt_held;
	logic                     nxt_ended;
	logic                     nxt_conf;
	logic [TotalWidth-1:0]    nxt_total;
	logic                     prefix_hit;

	kind_t                    res_kind [3];
	logic [7:0]               res_byte [3];
	logic [1:0]               res_n;
	logic                     res_found;

	logic                     grp_last;
	logic                     drain_done;
	logic                     grp_free;
	logic                     advance;

	always_comb begin
		nxt_phase  = phase_q;
		nxt_count  = count_q;
		nxt_remain = remain_q;
		nxt_match  = match_q;
		nxt_mode   = mode_q;
		nxt_held   = held_q;
		nxt_ended  = ended_q;
		nxt_conf   = conf_q;
		nxt_total  = total_q;
		count_inc  = count_q + 1'b1;
		prefix_hit = (match_q < 4'(PrefixLen)) && (byte_s1 == prefix_char(match_q));
		res_n      = 2'd0;
		res_found  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			res_kind[i] = KIND_AUDIO;
			res_byte[i] = 8'h00;
		end

		if (interval_q == '0) begin
			nxt_phase   = PH_AUDIO;
			nxt_count   = '0;
			nxt_total   = total_q + 1'b1;
			res_kind[0] = KIND_AUDIO;
			res_byte[0] = byte_s1;
			res_n       = 2'd1;
		end else if (phase_q == PH_LENGTH) begin
			nxt_remain = {byte_s1, 4'b0000};
			nxt_match  = '0;
			nxt_mode   = CM_PREFIX;
			nxt_held   = 1'b0;
			nxt_ended  = 1'b0;
			nxt_conf   = 1'b0;
			if (byte_s1 == 8'h00) begin
				res_kind[0] = KIND_END;
				res_found   = 1'b0;
				res_n       = 2'd1;
				nxt_phase   = PH_AUDIO;
				nxt_count   = '0;
				nxt_remain  = '0;
			end else begin
				nxt_phase = PH_META;
			end
		end else if (phase_q == PH_META) begin
			if (!ended_q && mode_q != CM_DONE) begin
				if (byte_s1 == 8'h00) begin
					nxt_ended = 1'b1;
					nxt_held  = 1'b0;
				end else if (mode_q == CM_PREFIX) begin
					if (prefix_hit) begin
						nxt_match = match_q + 1'b1;
					end else begin
						nxt_match = (byte_s1 == CHAR_S) ? 4'd1 : 4'd0;
					end
					if (nxt_match >= 4'(PrefixLen)) begin
						nxt_match = '0;
						nxt_mode  = CM_FIRST;
					end
				end else if (mode_q == CM_FIRST) begin
					res_kind[0] = KIND_TITLE;
					res_byte[0] = byte_s1;
					res_n       = 2'd1;
					nxt_mode    = CM_REST;
				end else if (held_q && byte_s1 == CHAR_SEMI) begin
					nxt_held = 1'b0;
					nxt_conf = 1'b1;
					nxt_mode = CM_DONE;
				end else begin
					if (held_q) begin
						res_kind[0] = KIND_TITLE;
						res_byte[0] = CHAR_QUOTE;
						res_n       = 2'd1;
					end
					if (byte_s1 == CHAR_QUOTE) begin
						nxt_held = 1'b1;
					end else begin
						nxt_held        = 1'b0;
						res_kind[res_n] = KIND_TITLE;
						res_byte[res_n] = byte_s1;
						res_n           = res_n + 1'b1;
					end
				end
			end
			if (remain_q != '0) begin
				nxt_remain = remain_q - 1'b1;
			end
			if (nxt_remain == '0) begin
				res_kind[res_n] = KIND_END;
				res_byte[res_n] = 8'h00;
				res_found       = nxt_conf;
				res_n           = res_n + 1'b1;
				nxt_phase       = PH_AUDIO;
				nxt_count       = '0;
				nxt_match       = '0;
				nxt_mode        = CM_PREFIX;
				nxt_held        = 1'b0;
				nxt_ended       = 1'b0;
				nxt_conf        = 1'b0;
			end
		end else begin
			nxt_phase   = PH_AUDIO;
			res_kind[0] = KIND_AUDIO;
			res_byte[0] = byte_s1;
			res_n       = 2'd1;
			nxt_total   = total_q + 1'b1;
			nxt_count   = count_inc;
			if (count_inc >= interval_q) begin
				nxt_count = '0;
				nxt_phase = PH_LENGTH;
			end
		end
	end

	assign out_valid  = (grp_n_q != 2'd0);
	assign grp_last   = (grp_idx_q == grp_n_q - 2'd1);
	assign drain_done = out_valid && out_ready && grp_last;
	assign grp_free   = !out_valid || drain_done;
	assign advance    = valid_s1 && (grp_free || res_n == 2'd0);
	assign in_ready   = !valid_s1 || advance;

	assign kind           = grp_kind_q[grp_idx_q];
	assign out_byte       = grp_byte_q[grp_idx_q];
	assign last           = grp_last;
	assign title_found    = (kind == KIND_END) ? grp_found_q : 1'b0;
	assign audio_position = (kind == KIND_END) ? grp_pos_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
		end else if (meta_interval_we) begin
			interval_q <= meta_interval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_AUDIO;
			count_q  <= '0;
			remain_q <= '0;
			match_q  <= '0;
			mode_q   <= CM_PREFIX;
			held_q   <= 1'b0;
			ended_q  <= 1'b0;
			conf_q   <= 1'b0;
			total_q  <= '0;
		end else if (advance) begin
			phase_q  <= nxt_phase;
			count_q  <= nxt_count;
			remain_q <= nxt_remain;
			match_q  <= nxt_match;
			mode_q   <= nxt_mode;
			held_q   <= nxt_held;
			ended_q  <= nxt_ended;
			conf_q   <= nxt_conf;
			total_q  <= nxt_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_n_q   <= 2'd0;
			grp_idx_q <= 2'd0;
		end else if (advance && res_n != 2'd0) begin
			grp_n_q   <= res_n;
			grp_idx_q <= 2'd0;
		end else if (drain_done) begin
			grp_n_q   <= 2'd0;
			grp_idx_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			grp_idx_q <= grp_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_n != 2'd0) begin
			grp_kind_q  <= res_kind;
			grp_byte_q  <= res_byte;
			grp_found_q <= res_found;
			grp_pos_q   <= total_q;
		end
	end

endmodule
`default_nettype wire

@@ hdl/icymd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer port checker
// Watches the top-level ports for result-channel consistency.
// ----------------------------------------------------------------------------
module icymd_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire [1:0]                        kind,
	input wire [7:0]                        out_byte,
	input wire                              title_found,
	input wire [icymd_pkg::TotalWidth-1:0]  audio_position,
	input wire                              last
);
	import icymd_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte))
		else $error("Result changed while the receiver stalled.");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_AUDIO || kind == KIND_TITLE || kind == KIND_END))
		else $error("Result kind outside the defined codes.");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> last && out_byte == 8'h00)
		else $error("Block end is not the final zero-byte result of its request.");

	a_side_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_END |-> !title_found && audio_position == '0)
		else $error("Block-end fields set on a byte result.");

endmodule

bind icy_metadata_stream_demux icymd_checker u_icymd_checker (.*);
`default_nettype wire

@@ sim/icy_metadata_stream_demux_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICY metadata stream demultiplexer testbench
// Walks a short table of directed stream bytes and interval writes, then a
// long random stream of audio runs and metadata blocks built around
// StreamTitle fields. Each result is checked against a cycle-free predictor
// of the demultiplexer while both handshakes stall at random in most settings.
// ----------------------------------------------------------------------------
module icy_metadata_stream_demux_tb;
	import icymd_pkg::*;

	localparam int CYCLE_LIMIT      = 1000000;
	localparam int HOLD_CYCLES      = 400;
	localparam int RAND_PER_SETTING = 85;
	localparam int NUM_ROWS         = 31;
	localparam int MAX_REPORTS      = 40;

	localparam logic [8*PrefixLen-1:0] TITLE_TAG = "StreamTitle='";

	typedef struct packed {
		kind_t                 k;
		logic [7:0]            data;
		logic                  found;
		logic [TotalWidth-1:0] pos;
		logic                  last;
	} demux_out_t;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_TYPED,
		ROW_CFG
	} row_op_t;

	typedef struct packed {
		row_op_t                  op;
		logic [IntervalWidth-1:0] value;
		demux_out_t               res;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{ROW_TYPED, 20'h00000, '{KIND_AUDIO, 8'h00, 1'b0, 48'd0, 1'b1}},
		'{ROW_TYPED, 20'h000FF, '{KIND_AUDIO, 8'hFF, 1'b0, 48'd0, 1'b1}},
		'{ROW_CFG,   20'hFFFFF, '0},
		'{ROW_BYTE,  20'h0003C, '0},
		'{ROW_BYTE,  20'h000C3, '0},
		'{ROW_CFG,   20'h00001, '0},
		'{ROW_BYTE,  20'h00077, '0},
		'{ROW_TYPED, 20'h00000, '{KIND_END, 8'h00, 1'b0, 48'd5, 1'b1}},
		'{ROW_BYTE,  20'h00001, '0},
		'{ROW_BYTE,  20'h00001, '0},
		'{ROW_BYTE,  20'h00053, '0},
		'{ROW_BYTE,  20'h00074, '0},
		'{ROW_BYTE,  20'h00072, '0},
		'{ROW_BYTE,  20'h00065, '0},
		'{ROW_BYTE,  20'h00061, '0},
		'{ROW_BYTE,  20'h0006D, '0},
		'{ROW_BYTE,  20'h00054, '0},
		'{ROW_BYTE,  20'h00069, '0},
		'{ROW_BYTE,  20'h00074, '0},
		'{ROW_BYTE,  20'h0006C, '0},
		'{ROW_BYTE,  20'h00065, '0},
		'{ROW_BYTE,  20'h0003D, '0},
		'{ROW_BYTE,  20'h00027, '0},
		'{ROW_BYTE,  20'h00027, '0},
		'{ROW_BYTE,  20'h00027, '0},
		'{ROW_BYTE,  20'h00058, '0},
		'{ROW_BYTE,  20'h00001, '0},
		'{ROW_BYTE,  20'h00001, '0},
		'{ROW_BYTE,  20'h00000, '0},
		'{ROW_CFG,   20'h00000, '0},
		'{ROW_TYPED, 20'h00080, '{KIND_AUDIO, 8'h80, 1'b0, 48'd0, 1'b1}}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     meta_interval_we;
	logic [IntervalWidth-1:0] meta_interval;
	logic                     in_valid;
	logic                     in_ready;
	logic [7:0]               in_byte;
	logic                     out_valid;
	logic                     out_ready;
	kind_t                    kind;
	logic [7:0]               out_byte;
	logic                     title_found;
	logic [TotalWidth-1:0]    audio_position;
	logic                     last;

	demux_out_t demux_out_q[$];
	logic [7:0] meta_block_q[$];

	logic [IntervalWidth-1:0] interval_reg;
	logic [1:0]               cur_phase;
	logic [IntervalWidth-1:0] audio_cnt;
	logic [RemainWidth-1:0]   meta_left;
	logic [3:0]               tag_pos;
	logic [1:0]               capture;
	logic                     quote_pending;
	logic                     text_done;
	logic                     title_ok;
	logic [TotalWidth-1:0]    audio_sum;

	int  error_count;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_request;
	bit  want_big_block;

	icy_metadata_stream_demux u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.meta_interval_we (meta_interval_we),
		.meta_interval    (meta_interval),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.out_byte         (out_byte),
		.title_found      (title_found),
		.audio_position   (audio_position),
		.last             (last)
	);

	function automatic logic [7:0] title_tag_byte(int p);
		return TITLE_TAG[8*(PrefixLen-1-p) +: 8];
	endfunction

	function automatic void emit_result(kind_t k, logic [7:0] d, logic f,
			logic [TotalWidth-1:0] p);
		demux_out_t r;
		r.k     = k;
		r.data  = d;
		r.found = f;
		r.pos   = p;
		r.last  = 1'b0;
		demux_out_q.push_back(r);
	endfunction

	function automatic void clear_title_scan();
		tag_pos       = '0;
		capture       = CM_PREFIX;
		quote_pending = 1'b0;
		text_done     = 1'b0;
		title_ok      = 1'b0;
	endfunction

	function automatic void close_block();
		emit_result(KIND_END, 8'h00, title_ok, audio_sum);
		cur_phase = PH_AUDIO;
		audio_cnt = '0;
		meta_left = '0;
		clear_title_scan();
	endfunction

	function automatic void scan_title_byte(logic [7:0] b);
		if (text_done || capture == CM_DONE)
			return;
		if (b == 8'h00) begin
			text_done     = 1'b1;
			quote_pending = 1'b0;
			return;
		end
		if (capture == CM_PREFIX) begin
			if (tag_pos < 4'(PrefixLen) && b == title_tag_byte(int'(tag_pos)))
				tag_pos = tag_pos + 4'd1;
			else
				tag_pos = (b == CHAR_S) ? 4'd1 : 4'd0;
			if (tag_pos >= 4'(PrefixLen)) begin
				tag_pos = '0;
				capture = CM_FIRST;
			end
			return;
		end
		if (capture == CM_FIRST) begin
			emit_result(KIND_TITLE, b, 1'b0, '0);
			capture = CM_REST;
			return;
		end
		if (quote_pending) begin
			quote_pending = 1'b0;
			if (b == CHAR_SEMI) begin
				title_ok = 1'b1;
				capture  = CM_DONE;
				return;
			end
			emit_result(KIND_TITLE, CHAR_QUOTE, 1'b0, '0);
		end
		if (b == CHAR_QUOTE)
			quote_pending = 1'b1;
		else
			emit_result(KIND_TITLE, b, 1'b0, '0);
	endfunction

	function automatic void demux_byte(logic [7:0] b);
		int n_prior;
		n_prior = demux_out_q.size();
		if (interval_reg == '0) begin
			cur_phase = PH_AUDIO;
			audio_cnt = '0;
			audio_sum = audio_sum + 1'b1;
			emit_result(KIND_AUDIO, b, 1'b0, '0);
		end else if (cur_phase == PH_LENGTH) begin
			meta_left = {b, 4'b0000};
			clear_title_scan();
			if (meta_left == '0)
				close_block();
			else
				cur_phase = PH_META;
		end else if (cur_phase == PH_META) begin
			scan_title_byte(b);
			if (meta_left != '0)
				meta_left = meta_left - 1'b1;
			if (meta_left == '0)
				close_block();
		end else begin
			cur_phase = PH_AUDIO;
			emit_result(KIND_AUDIO, b, 1'b0, '0);
			audio_sum = audio_sum + 1'b1;
			audio_cnt = audio_cnt + 1'b1;
			if (audio_cnt >= interval_reg) begin
				audio_cnt = '0;
				cur_phase = PH_LENGTH;
			end
		end
		if (demux_out_q.size() > n_prior)
			demux_out_q[$].last = 1'b1;
	endfunction

	function automatic void check_field(string name, logic [TotalWidth-1:0] want,
			logic [TotalWidth-1:0] got);
		if (got !== want) begin
			if (error_count < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			error_count++;
		end
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic typed,
			input demux_out_t typed_res);
		int n_prior;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_byte  = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_prior = demux_out_q.size();
		demux_byte(b);
		if (typed) begin
			while (demux_out_q.size() > n_prior)
				void'(demux_out_q.pop_back());
			demux_out_q.push_back(typed_res);
		end
		@(negedge clk);
	endtask

	task automatic write_interval(input logic [IntervalWidth-1:0] v);
		in_valid = 1'b0;
		while (demux_out_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		meta_interval_we = 1'b1;
		meta_interval    = v;
		@(posedge clk);
		interval_reg = v;
		@(negedge clk);
		meta_interval_we = 1'b0;
		meta_block_q.delete();
	endtask

	task automatic run_stream(input int n_items);
		int         sent;
		int         len;
		int         shape;
		int         junk;
		int         tl;
		int         r;
		logic [7:0] b;
		sent = 0;
		while (sent < n_items) begin
			if (interval_reg != '0 && cur_phase == PH_LENGTH) begin
				r = $urandom_range(99, 0);
				if (want_big_block) begin
					b = 8'hFF;
					want_big_block = 1'b0;
				end else if (r < 10) begin
					b = 8'h00;
				end else if (r < 60) begin
					b = 8'h01;
				end else if (r < 85) begin
					b = 8'h02;
				end else begin
					b = 8'($urandom_range(8, 3));
				end
				len   = int'(b) * 16;
				shape = $urandom_range(9, 0);
				meta_block_q.delete();
				if (shape < 7) begin
					junk = (len > 16) ? $urandom_range(6, 0) : 0;
					repeat (junk) meta_block_q.push_back(8'($urandom_range(126, 32)));
					for (int i = 0; i < PrefixLen; i++)
						meta_block_q.push_back(title_tag_byte(i));
					tl = (len > 16) ? $urandom_range(12, 1) : 1;
					repeat (tl) begin
						if ($urandom_range(99, 0) < 15)
							meta_block_q.push_back(CHAR_QUOTE);
						else
							meta_block_q.push_back(8'($urandom_range(126, 32)));
					end
					if (shape < 5) begin
						meta_block_q.push_back(CHAR_QUOTE);
						meta_block_q.push_back(CHAR_SEMI);
					end else if (shape == 5) begin
						meta_block_q.push_back(8'h00);
					end
				end else if (shape == 7) begin
					tl = $urandom_range(PrefixLen - 1, 1);
					for (int i = 0; i < tl; i++)
						meta_block_q.push_back(title_tag_byte(i));
				end
				while (meta_block_q.size() < len)
					meta_block_q.push_back(shape[0] ? 8'h00 : 8'($urandom));
				while (meta_block_q.size() > len)
					void'(meta_block_q.pop_back());
			end else if (interval_reg != '0 && cur_phase == PH_META &&
					meta_block_q.size() != 0) begin
				b = meta_block_q.pop_front();
			end else begin
				b = 8'($urandom);
			end
			push_byte(b, 1'b0, '0);
			sent++;
		end
	endtask

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready    = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		demux_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (demux_out_q.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: result with nothing pending, kind %0d byte %0h",
						$time, kind, out_byte);
				error_count++;
			end else begin
				want = demux_out_q.pop_front();
				check_field("kind", TotalWidth'(want.k), TotalWidth'(kind));
				check_field("out_byte", TotalWidth'(want.data), TotalWidth'(out_byte));
				check_field("title_found", TotalWidth'(want.found),
					TotalWidth'(title_found));
				check_field("audio_position", want.pos, audio_position);
				check_field("last", TotalWidth'(want.last), TotalWidth'(last));
			end
		end
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		meta_interval_we = 1'b0;
		meta_interval    = '0;
		in_valid         = 1'b0;
		in_byte          = '0;
		error_count      = 0;
		cycle_count      = 0;
		hold_request     = 1'b0;
		want_big_block   = 1'b0;
		send_idle_pct    = 32;
		recv_idle_pct    = 60;
		interval_reg     = '0;
		cur_phase        = PH_AUDIO;
		audio_cnt        = '0;
		meta_left        = '0;
		audio_sum        = '0;
		clear_title_scan();

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			case (DIRECTED_ROWS[i].op)
				ROW_CFG:   write_interval(DIRECTED_ROWS[i].value);
				ROW_TYPED: push_byte(DIRECTED_ROWS[i].value[7:0], 1'b1,
					DIRECTED_ROWS[i].res);
				default:   push_byte(DIRECTED_ROWS[i].value[7:0], 1'b0, '0);
			endcase
		end

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 60 : 0;
			recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 32 : 0;
			for (int sub = 0; sub < 2; sub++) begin
				if (mode == 1 && sub == 1)
					write_interval('0);
				else
					write_interval(IntervalWidth'($urandom_range(24, 1)));
				if (mode == 2 && sub == 0)
					hold_request = 1'b1;
				if (mode == 2 && sub == 1)
					want_big_block = 1'b1;
				run_stream(RAND_PER_SETTING);
			end
		end

		in_valid = 1'b0;
		while (demux_out_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
